// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the list store.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ils_pkg.sv =====
// Package of the indexed list store: sizes, operation and status codes, cell command type.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ils_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int FUNC_W  = 2;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic insert;
    logic remove;
    cmp_t pos;
  } cell_cmd_t;

  function automatic data_t word_to_data(input logic [WORD_W-1:0] w);
    data_t d;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      d[i] = (i < WORD_W) ? w[i] : 1'b0;
    end
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] data_to_word(input data_t d);
    logic [WORD_W-1:0] w;
    for (int i = 0; i < WORD_W; i++) begin
      w[i] = (i < DATA_WIDTH) ? d[i] : 1'b0;
    end
    return w;
  endfunction

  function automatic cmp_t cnt_to_cmp(input cnt_t c);
    cmp_t r;
    for (int i = 0; i < CMP_W; i++) begin
      r[i] = (i < CNT_W) ? c[i] : 1'b0;
    end
    return r;
  endfunction

  function automatic cmp_t pos_to_cmp(input logic [POS_W-1:0] p);
    cmp_t r;
    for (int i = 0; i < CMP_W; i++) begin
      r[i] = (i < POS_W) ? p[i] : 1'b0;
    end
    return r;
  endfunction

  function automatic cmp_t idx_to_cmp(input logic [IDX_W-1:0] x);
    cmp_t r;
    for (int i = 0; i < CMP_W; i++) begin
      r[i] = (i < IDX_W) ? x[i] : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_to_count(input cnt_t c);
    logic [COUNT_W-1:0] r;
    for (int i = 0; i < COUNT_W; i++) begin
      r[i] = (i < CNT_W) ? c[i] : 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ils_cell.sv =====
// One storage cell of the list: holds one entry and takes its neighbor's word on a shift.
// Depends on ils_pkg for the data and command types.
`default_nettype none

module ils_cell (
  input  wire                          clk,
  input  wire  [ils_pkg::IDX_W-1:0]    cell_idx,
  input  ils_pkg::cell_cmd_t           cmd,
  input  ils_pkg::data_t               new_word,
  input  ils_pkg::data_t               prev_data,
  input  ils_pkg::data_t               next_data,
  output ils_pkg::data_t               data
);

  ils_pkg::data_t data_r;
  ils_pkg::data_t data_nxt;
  ils_pkg::cmp_t  my_idx;

  assign my_idx = ils_pkg::idx_to_cmp(cell_idx);

  always_comb begin
    data_nxt = data_r;
    if (cmd.insert && (my_idx == cmd.pos)) begin
      data_nxt = new_word;
    end else if (cmd.insert && (my_idx > cmd.pos)) begin
      data_nxt = prev_data;
    end else if (cmd.remove && (my_idx >= cmd.pos)) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_store.sv =====
// Top level of the indexed list store: operation decode, entry count and the row of cells.
// Depends on ils_pkg and ils_cell.
`default_nettype none

// The store takes one transaction per clock cycle: busy is low whenever reset is released,
// and every operation, including an insert or remove that moves all entries, finishes in the
// cycle it is accepted because each cell shifts toward its neighbor at the same clock edge.
// The result appears on the out_ ports in the cycle after acceptance, marked by
// out_valid for that single cycle; the receiver cannot stall it and must capture it then.
module indexed_list_store (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [ils_pkg::FUNC_W-1:0]     in_func,
  input  wire  [ils_pkg::POS_W-1:0]      in_position,
  input  wire  [ils_pkg::WORD_W-1:0]     in_word_in,
  output logic                           out_valid,
  output logic [ils_pkg::WORD_W-1:0]     out_word_out,
  output logic [ils_pkg::STAT_W-1:0]     out_status,
  output logic [ils_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_is_empty
);

  ils_pkg::cnt_t              occ_r;
  ils_pkg::cnt_t              occ_nxt;
  logic                       valid_r;
  logic [ils_pkg::WORD_W-1:0] word_r;
  logic [ils_pkg::WORD_W-1:0] word_nxt;
  ils_pkg::status_t           status_r;
  ils_pkg::status_t           status_nxt;
  logic [ils_pkg::COUNT_W-1:0] count_r;
  logic                       empty_r;

  logic                       accept;
  ils_pkg::func_t             func;
  ils_pkg::cmp_t              pos;
  ils_pkg::cmp_t              occ;
  ils_pkg::cell_cmd_t         cmd;
  ils_pkg::data_t             new_word;
  ils_pkg::data_t             cell_data [ils_pkg::CAPACITY];
  ils_pkg::data_t             rd_data;

  assign busy     = !rst_n;
  assign accept   = start && !busy;
  assign func     = ils_pkg::func_t'(in_func);
  assign pos      = ils_pkg::pos_to_cmp(in_position);
  assign occ      = ils_pkg::cnt_to_cmp(occ_r);
  assign new_word = ils_pkg::word_to_data(in_word_in);
  assign rd_data  = cell_data[pos[ils_pkg::IDX_W-1:0]];

  always_comb begin
    cmd.insert = 1'b0;
    cmd.remove = 1'b0;
    cmd.pos    = pos;
    occ_nxt    = occ_r;
    word_nxt   = '0;
    status_nxt = ils_pkg::ST_OK;
    case (func)
      ils_pkg::OP_INSERT: begin
        if (pos > occ) begin
          status_nxt = ils_pkg::ST_BAD_INDEX;
        end else if (occ >= ils_pkg::CMP_W'(ils_pkg::CAPACITY)) begin
          status_nxt = ils_pkg::ST_FULL;
        end else begin
          cmd.insert = accept;
          occ_nxt    = occ_r + 1'b1;
        end
      end
      ils_pkg::OP_REMOVE, ils_pkg::OP_GET: begin
        if (occ_r == '0) begin
          status_nxt = ils_pkg::ST_EMPTY;
        end else if (pos >= occ) begin
          status_nxt = ils_pkg::ST_BAD_INDEX;
        end else begin
          word_nxt = ils_pkg::data_to_word(rd_data);
          if (func == ils_pkg::OP_REMOVE) begin
            cmd.remove = accept;
            occ_nxt    = occ_r - 1'b1;
          end
        end
      end
      ils_pkg::OP_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < ils_pkg::CAPACITY; gi++) begin : g_cell
      ils_pkg::data_t prev_d;
      ils_pkg::data_t next_d;
      if (gi == 0) begin : g_first
        assign prev_d = new_word;
      end else begin : g_mid_prev
        assign prev_d = cell_data[gi-1];
      end
      if (gi == ils_pkg::CAPACITY - 1) begin : g_last
        assign next_d = cell_data[gi];
      end else begin : g_mid_next
        assign next_d = cell_data[gi+1];
      end
      ils_cell u_cell (
        .clk       (clk),
        .cell_idx  (ils_pkg::IDX_W'(gi)),
        .cmd       (cmd),
        .new_word  (new_word),
        .prev_data (prev_d),
        .next_data (next_d),
        .data      (cell_data[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r   <= word_nxt;
      status_r <= status_nxt;
      count_r  <= ils_pkg::cnt_to_count(occ_nxt);
      empty_r  <= (occ_nxt == '0);
    end
  end

  assign out_valid       = valid_r;
  assign out_word_out    = word_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = empty_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ils_checker.sv =====
// Port-level checker for the indexed list store and the bind that attaches it to the top level.
// Depends on ils_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ils_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire [ils_pkg::FUNC_W-1:0]    in_func,
  input wire [ils_pkg::POS_W-1:0]     in_position,
  input wire [ils_pkg::WORD_W-1:0]    in_word_in,
  input wire                          out_valid,
  input wire [ils_pkg::WORD_W-1:0]    out_word_out,
  input wire [ils_pkg::STAT_W-1:0]    out_status,
  input wire [ils_pkg::COUNT_W-1:0]   out_entry_count,
  input wire                          out_is_empty
);

  logic accepted;
  logic clear_cmd;

  assign accepted  = start && !busy;
  assign clear_cmd = accepted && (in_func == ils_pkg::OP_CLEAR) && (in_position <= in_position)
                     && (in_word_in == in_word_in);

  // Every accepted transaction yields exactly one result in the following cycle.
  `ASSERT_NEXT(a_result_follows, clk, rst_n, accepted, out_valid)
  `ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !accepted, !out_valid)
  // A clear always succeeds and leaves the list empty.
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_cmd,
               (out_status == ils_pkg::ST_OK) && out_is_empty && (out_entry_count == '0))
  // A failed operation returns no data word.
  `ASSERT_SAME(a_fail_no_word, clk, rst_n, out_valid && (out_status != ils_pkg::ST_OK),
               out_word_out == '0)
  // The empty flag agrees with the reported count.
  `ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid, out_is_empty == (out_entry_count == '0))

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

`default_nettype wire
